>>> rtl/core/epvg_pkg.sv
// Package with shared types, constants and the arctangent table of the ellipse polygon vertex generator.
package epvg_pkg;

  localparam int unsigned DefMaxVertices       = 4095;
  localparam int unsigned DefRotationIterations = 20;
  localparam int unsigned DefFractionBits      = 16;

  localparam int unsigned DataW  = 32;
  localparam int unsigned VnumW  = 12;
  localparam int unsigned FixW   = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TrigW  = 34;
  localparam int unsigned DivW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS_H   = 3'd0,
    CFG_RADIUS_V   = 3'd1,
    CFG_REL_MASK   = 3'd2,
    CFG_REF_WIDTH  = 3'd3,
    CFG_REF_HEIGHT = 3'd4,
    CFG_FIXED_CNT  = 3'd5,
    CFG_SCALE      = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_RAD_H,
    MUL_RAD_V,
    MUL_COORD_X,
    MUL_COORD_Y
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_DIST,
    DIV_RATIO,
    DIV_PROBE,
    DIV_VERTEX
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RH_MUL,
    ST_RH_FIN,
    ST_RV_MUL,
    ST_RV_FIN,
    ST_COUNT,
    ST_D_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_S_CHECK,
    ST_P_WAIT,
    ST_PC_WAIT,
    ST_V_BEGIN,
    ST_V_GO,
    ST_V_WAIT,
    ST_VC_WAIT,
    ST_X_MUL,
    ST_X_FIN,
    ST_Y_MUL,
    ST_Y_FIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rad_h_ld;
    logic     rad_v_ld;
    logic     restart_clr;
    logic     total_fixed_ld;
    logic     total_auto_ld;
    logic     search_init;
    logic     search_upd;
    logic     div_start;
    div_sel_e div_sel;
    logic     d_ld;
    logic     r_ld;
    logic     r_zero;
    logic     cordic_start;
    logic     vtx_begin;
    logic     x_ld;
    logic     y_ld;
    logic     out_ld;
  } epvg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
    logic ra_zero;
    logic fixed_ok;
    logic search_more;
    logic out_free;
  } epvg_status_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/epvg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module epvg_div import epvg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW-1:0] rem_q, quo_q, dvs_q;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q;
  logic [DivW:0]   rem_sh, rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/epvg_cordic.sv
// Iterative rotation unit giving cosine and sine in Q4.30 of a 32-bit turn phase.
module epvg_cordic import epvg_pkg::*; #(
  parameter int unsigned ROTATION_ITERATIONS = DefRotationIterations
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [31:0]             phase_i,
  output logic                    done_o,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);

  localparam logic signed [TrigW-1:0] Gain = TrigW'(652032874);
  localparam logic [4:0] LastIdx = 5'(ROTATION_ITERATIONS - 1);

  logic signed [TrigW-1:0] x_q, y_q, z_q, dx, dy, at;
  logic [1:0]              quad_q;
  logic [4:0]              idx_q;
  logic                    busy_q, done_q;

  assign dx = y_q >>> idx_q;
  assign dy = x_q >>> idx_q;
  assign at = $signed({2'b00, atan_turns(idx_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= busy_q && (idx_q == LastIdx);
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 5'd1;
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= Gain;
      y_q    <= '0;
      z_q    <= $signed({4'b0000, phase_i[29:0]});
      quad_q <= phase_i[31:30];
    end else if (busy_q) begin
      if (!z_q[TrigW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    unique case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

>>> rtl/core/epvg_datapath.sv
// Datapath: configuration, radii, count search, divider, rotator, multiplier and output word.
module epvg_datapath import epvg_pkg::*; #(
  parameter int unsigned MAX_VERTICES        = DefMaxVertices,
  parameter int unsigned ROTATION_ITERATIONS = DefRotationIterations,
  parameter int unsigned FRACTION_BITS       = DefFractionBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  epvg_cmd_t               cmd_i,
  output epvg_status_t            status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] vertex_x_o,
  output logic signed [DataW-1:0] vertex_y_o,
  output logic [VnumW-1:0]        vertex_number_o,
  output logic                    is_first_o,
  output logic                    is_last_o
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned MidW = CntW + 2;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_VERTICES);
  localparam logic [CntW-1:0] MinCnt = CntW'(3);
  localparam logic [DivW-1:0] DistNum = DivW'(1) << (2 * FRACTION_BITS - 3);
  localparam logic [DivW-1:0] RoundF = DivW'(1) << (FRACTION_BITS - 1);
  localparam logic [30:0] RadLim = 31'(1) << 30;
  localparam logic signed [DataW-1:0] RadPos = DataW'(1) << 30;
  localparam logic signed [DataW-1:0] RadNeg = -(DataW'(1) << 30);
  localparam int unsigned ProdW = 2 * TrigW;

  // Configuration.
  logic [DataW-1:0] rad_h_cfg_q, rad_v_cfg_q, ref_w_q, ref_h_q, scale_q;
  logic [1:0]       rel_q;
  logic [FixW-1:0]  fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_h_cfg_q <= '0;
      rad_v_cfg_q <= '0;
      rel_q       <= '0;
      ref_w_q     <= '0;
      ref_h_q     <= '0;
      fixed_q     <= '0;
      scale_q     <= DataW'(1) << FRACTION_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RADIUS_H:   rad_h_cfg_q <= cfg_data_i;
        CFG_RADIUS_V:   rad_v_cfg_q <= cfg_data_i;
        CFG_REL_MASK:   rel_q       <= cfg_data_i[1:0];
        CFG_REF_WIDTH:  ref_w_q     <= cfg_data_i;
        CFG_REF_HEIGHT: ref_h_q     <= cfg_data_i;
        CFG_FIXED_CNT:  fixed_q     <= cfg_data_i[FixW-1:0];
        CFG_SCALE:      scale_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State.
  logic signed [DataW-1:0] rad_h_q, rad_v_q, x_q, y_q;
  logic [CntW-1:0]         total_q, next_q, k_q, lo_q, hi_q;
  logic [DivW-1:0]         d_q;
  logic [30:0]             r_q;
  logic signed [ProdW-1:0] prod_q;

  // Divider and rotator.
  logic            div_done, cor_done;
  logic [DivW-1:0] div_num, div_den, quo;
  logic signed [TrigW-1:0] cos_v, sin_v;

  logic [DataW-1:0] scale_nz;
  logic [DataW:0]   abs_sum;
  logic [30:0]      ra;
  logic [MidW-1:0]  mid;

  assign scale_nz = (scale_q == '0) ? DataW'(1) : scale_q;
  assign abs_sum  = {1'b0, (rad_h_q[DataW-1] ? -rad_h_q : rad_h_q)}
                  + {1'b0, (rad_v_q[DataW-1] ? -rad_v_q : rad_v_q)};
  assign ra       = abs_sum[31:1];
  assign mid      = MidW'(lo_q) + ((MidW'(hi_q) - MidW'(lo_q) + MidW'(1)) >> 1);

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_DIST: begin
        div_num = DistNum + DivW'(scale_nz >> 1);
        div_den = DivW'(scale_nz);
      end
      DIV_RATIO: begin
        div_num = DivW'(ra) << 30;
        div_den = DivW'(ra) + d_q;
      end
      DIV_PROBE: begin
        div_num = DivW'(1) << 32;
        div_den = DivW'((mid << 1) - MidW'(1));
      end
      default: begin
        div_num = DivW'(k_q) << 32;
        div_den = DivW'(total_q);
      end
    endcase
  end

  epvg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  epvg_cordic #(
    .ROTATION_ITERATIONS (ROTATION_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .phase_i (quo[31:0]),
    .done_o  (cor_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // Shared multiplier.
  logic [DataW-1:0] mag_h, mag_v;
  logic signed [TrigW-1:0] mul_a, mul_b;

  assign mag_h = rad_h_cfg_q[DataW-1] ? -rad_h_cfg_q : rad_h_cfg_q;
  assign mag_v = rad_v_cfg_q[DataW-1] ? -rad_v_cfg_q : rad_v_cfg_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RAD_H: begin
        mul_a = $signed({2'b00, mag_h});
        mul_b = $signed({2'b00, ref_w_q});
      end
      MUL_RAD_V: begin
        mul_a = $signed({2'b00, mag_v});
        mul_b = $signed({2'b00, ref_h_q});
      end
      MUL_COORD_X: begin
        mul_a = cos_v;
        mul_b = TrigW'(rad_h_q);
      end
      default: begin
        mul_a = sin_v;
        mul_b = TrigW'(rad_v_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Effective radius.
  logic [DataW-1:0]        fin_raw;
  logic                    fin_rel;
  logic [DivW-1:0]         rel_round, rel_shift;
  logic [30:0]             rel_mag;
  logic signed [DataW-1:0] fin_rad;

  assign fin_raw   = cmd_i.rad_v_ld ? rad_v_cfg_q : rad_h_cfg_q;
  assign fin_rel   = cmd_i.rad_v_ld ? rel_q[1] : rel_q[0];
  assign rel_round = prod_q[DivW-1:0] + RoundF;
  assign rel_shift = rel_round >> FRACTION_BITS;
  assign rel_mag   = (rel_shift > DivW'(RadLim)) ? RadLim : rel_shift[30:0];

  always_comb begin
    if (fin_rel) begin
      fin_rad = fin_raw[DataW-1] ? -$signed({1'b0, rel_mag}) : $signed({1'b0, rel_mag});
    end else if ($signed(fin_raw) > RadPos) begin
      fin_rad = RadPos;
    end else if ($signed(fin_raw) < RadNeg) begin
      fin_rad = RadNeg;
    end else begin
      fin_rad = $signed(fin_raw);
    end
  end

  // Coordinate.
  logic signed [ProdW-1:0] coord_sum;
  logic signed [ProdW-1:0] coord_sh;
  logic signed [39:0]      coord_wide;
  logic signed [DataW-1:0] coord_rad, coord;

  assign coord_rad  = cmd_i.y_ld ? rad_v_q : rad_h_q;
  assign coord_sum  = prod_q + (ProdW'(1) << 29);
  assign coord_sh   = coord_sum >>> 30;
  assign coord_wide = 40'(coord_rad) + $signed(coord_sh[39:0]);

  always_comb begin
    if (coord_wide > 40'sd2147483647) begin
      coord = 32'sh7FFFFFFF;
    end else if (coord_wide < -40'sd2147483648) begin
      coord = 32'sh80000000;
    end else begin
      coord = coord_wide[DataW-1:0];
    end
  end

  // Count and vertex bookkeeping.
  logic fits;
  logic [CntW-1:0] k_next;

  assign fits   = cos_v <= $signed({3'b000, r_q});
  assign k_next = (CntW'(k_q + CntW'(1)) >= total_q) ? '0 : CntW'(k_q + CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_h_q <= '0;
      rad_v_q <= '0;
      total_q <= MinCnt;
      next_q  <= '0;
    end else begin
      if (cmd_i.rad_h_ld) begin
        rad_h_q <= fin_rad;
      end
      if (cmd_i.rad_v_ld) begin
        rad_v_q <= fin_rad;
      end
      if (cmd_i.restart_clr) begin
        next_q <= '0;
      end
      if (cmd_i.total_fixed_ld) begin
        total_q <= (FixW'(fixed_q) > FixW'(MAX_VERTICES) && MAX_VERTICES < (1 << FixW))
                 ? MaxCnt : CntW'(fixed_q);
      end
      if (cmd_i.total_auto_ld) begin
        total_q <= lo_q;
      end
      if (cmd_i.out_ld) begin
        next_q <= k_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.d_ld) begin
      d_q <= quo;
    end
    if (cmd_i.r_ld) begin
      r_q <= quo[30:0];
    end
    if (cmd_i.r_zero) begin
      r_q <= '0;
    end
    if (cmd_i.search_init) begin
      lo_q <= MinCnt;
      hi_q <= MaxCnt;
    end
    if (cmd_i.search_upd) begin
      if (fits) begin
        lo_q <= CntW'(mid);
      end else begin
        hi_q <= CntW'(mid - MidW'(1));
      end
    end
    if (cmd_i.vtx_begin) begin
      k_q <= (next_q >= total_q) ? '0 : next_q;
    end
    if (cmd_i.x_ld) begin
      x_q <= coord;
    end
    if (cmd_i.y_ld) begin
      y_q <= coord;
    end
  end

  // Output word.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      vertex_x_o      <= x_q;
      vertex_y_o      <= y_q;
      vertex_number_o <= VnumW'(k_q);
      is_first_o      <= (k_q == '0);
      is_last_o       <= (CntW'(k_q + CntW'(1)) == total_q);
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.div_done    = div_done;
  assign status_o.cordic_done = cor_done;
  assign status_o.ra_zero     = (ra == '0);
  assign status_o.fixed_ok    = (fixed_q >= FixW'(3));
  assign status_o.search_more = (lo_q < hi_q);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

>>> rtl/core/epvg_ctrl.sv
// Controller state machine sequencing restart, count search and vertex generation.
module epvg_ctrl import epvg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         restart_i,
  input  epvg_status_t status_i,
  output epvg_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = restart_i ? ST_RH_MUL : ST_V_BEGIN;
        end
      end
      ST_RH_MUL: state_d = ST_RH_FIN;
      ST_RH_FIN: state_d = ST_RV_MUL;
      ST_RV_MUL: state_d = ST_RV_FIN;
      ST_RV_FIN: state_d = ST_COUNT;
      ST_COUNT:  state_d = status_i.fixed_ok ? ST_V_BEGIN : ST_D_WAIT;
      ST_D_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_R_GO;
        end
      end
      ST_R_GO:   state_d = status_i.ra_zero ? ST_S_CHECK : ST_R_WAIT;
      ST_R_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_S_CHECK;
        end
      end
      ST_S_CHECK: state_d = status_i.search_more ? ST_P_WAIT : ST_V_BEGIN;
      ST_P_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_PC_WAIT;
        end
      end
      ST_PC_WAIT: begin
        if (status_i.cordic_done) begin
          state_d = ST_S_CHECK;
        end
      end
      ST_V_BEGIN: state_d = ST_V_GO;
      ST_V_GO:    state_d = ST_V_WAIT;
      ST_V_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_VC_WAIT;
        end
      end
      ST_VC_WAIT: begin
        if (status_i.cordic_done) begin
          state_d = ST_X_MUL;
        end
      end
      ST_X_MUL: state_d = ST_X_FIN;
      ST_X_FIN: state_d = ST_Y_MUL;
      ST_Y_MUL: state_d = ST_Y_FIN;
      ST_Y_FIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_RAD_H;
    cmd_o.div_sel = DIV_DIST;
    unique case (state_q)
      ST_RH_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RAD_H;
      end
      ST_RH_FIN: cmd_o.rad_h_ld = 1'b1;
      ST_RV_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RAD_V;
      end
      ST_RV_FIN: begin
        cmd_o.rad_v_ld    = 1'b1;
        cmd_o.restart_clr = 1'b1;
      end
      ST_COUNT: begin
        if (status_i.fixed_ok) begin
          cmd_o.total_fixed_ld = 1'b1;
        end else begin
          cmd_o.search_init = 1'b1;
          cmd_o.div_start   = 1'b1;
          cmd_o.div_sel     = DIV_DIST;
        end
      end
      ST_D_WAIT: cmd_o.d_ld = status_i.div_done;
      ST_R_GO: begin
        cmd_o.div_sel = DIV_RATIO;
        if (status_i.ra_zero) begin
          cmd_o.r_zero = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_R_WAIT: cmd_o.r_ld = status_i.div_done;
      ST_S_CHECK: begin
        cmd_o.div_sel = DIV_PROBE;
        if (status_i.search_more) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.total_auto_ld = 1'b1;
        end
      end
      ST_P_WAIT:  cmd_o.cordic_start = status_i.div_done;
      ST_PC_WAIT: begin
        cmd_o.div_sel    = DIV_PROBE;
        cmd_o.search_upd = status_i.cordic_done;
      end
      ST_V_BEGIN: cmd_o.vtx_begin = 1'b1;
      ST_V_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_VERTEX;
      end
      ST_V_WAIT: cmd_o.cordic_start = status_i.div_done;
      ST_X_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_COORD_X;
      end
      ST_X_FIN: cmd_o.x_ld = 1'b1;
      ST_Y_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_COORD_Y;
      end
      ST_Y_FIN: cmd_o.y_ld = 1'b1;
      ST_EMIT:  cmd_o.out_ld = status_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> rtl/core/ellipse_polygon_vertex_generator_unit.sv
// Top level of the ellipse polygon vertex generator.
// Each accepted word yields one vertex word. For a plain vertex request the shared
// radix-2 divider forms the angle, the rotator then turns it into cosine and sine,
// and the shared multiplier scales both axes.
// A restart with a fixed count first sets both effective radii; with the automatic
// count it adds up to two more divisions and a binary search of about
// log2(MAX_VERTICES) probes, each one division plus one rotation.
// A finished vertex waits in the output register while the next word is taken.
module ellipse_polygon_vertex_generator_unit import epvg_pkg::*; #(
  parameter int unsigned MAX_VERTICES        = DefMaxVertices,
  parameter int unsigned ROTATION_ITERATIONS = DefRotationIterations,
  parameter int unsigned FRACTION_BITS       = DefFractionBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    restart_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] vertex_x_o,
  output logic signed [DataW-1:0] vertex_y_o,
  output logic [VnumW-1:0]        vertex_number_o,
  output logic                    is_first_o,
  output logic                    is_last_o
);

  epvg_cmd_t    cmd;
  epvg_status_t status;

  epvg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  epvg_datapath #(
    .MAX_VERTICES        (MAX_VERTICES),
    .ROTATION_ITERATIONS (ROTATION_ITERATIONS),
    .FRACTION_BITS       (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .vertex_number_o (vertex_number_o),
    .is_first_o      (is_first_o),
    .is_last_o       (is_last_o)
  );

endmodule
